// ----- rtl/chi_pkg.sv -----
// Shared definitions for the cubic Hermite interpolator: default widths,
// status codes and the per-stage control word that rides along the pipeline.
// No dependencies.
`default_nettype none
package chi_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    // Control word carried beside the data of every stage.
    typedef struct packed {
        logic    vld;
        t_status status;
    } t_ctl;

endpackage
`default_nettype wire

// ----- rtl/chi_div.sv -----
// Pipelined restoring divider: (num << FRAC_BITS) / den, rounded to nearest,
// one quotient bit per stage plus a rounding stage. Depends on chi_pkg.
`default_nettype none
module chi_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SIDE_W     = 160
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire chi_pkg::t_ctl         i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_num,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    input  wire logic [SIDE_W-1:0]     i_side,
    output chi_pkg::t_ctl              o_ctl,
    output logic [FRAC_BITS:0]         o_quo,
    output logic [SIDE_W-1:0]          o_side
);
    import chi_pkg::*;

    localparam int NS = FRAC_BITS + 1;

    logic [DATA_WIDTH-1:0] r_rem  [NS];
    logic [FRAC_BITS:0]    r_quo  [NS];
    logic [DATA_WIDTH-1:0] r_den  [NS];
    logic [SIDE_W-1:0]     r_side [NS];
    t_ctl                  r_ctl  [NS];
    logic [FRAC_BITS:0]    r_qout;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [DATA_WIDTH:0]   n_shift;
            logic [DATA_WIDTH:0]   n_diff;
            logic                  n_ge;
            logic [DATA_WIDTH-1:0] n_den_in;
            t_ctl                  n_ctl_in;
            logic [SIDE_W-1:0]     n_side_in;
            logic [FRAC_BITS:0]    n_quo;
            if (k == 0) begin : g_first
                assign n_shift   = {1'b0, i_num};
                assign n_den_in  = i_den;
                assign n_ctl_in  = i_ctl;
                assign n_side_in = i_side;
                assign n_quo     = (FRAC_BITS+1)'(n_ge);
            end else begin : g_next
                assign n_shift   = {r_rem[k-1], 1'b0};
                assign n_den_in  = r_den[k-1];
                assign n_ctl_in  = r_ctl[k-1];
                assign n_side_in = r_side[k-1];
                assign n_quo     = {r_quo[k-1][FRAC_BITS-1:0], n_ge};
            end
            assign n_ge   = n_shift >= {1'b0, n_den_in};
            assign n_diff = n_shift - {1'b0, n_den_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[k] <= '0;
                end else if (i_en) begin
                    r_ctl[k] <= n_ctl_in;
                end
                if (i_en) begin
                    r_rem[k]  <= n_ge ? n_diff[DATA_WIDTH-1:0] : n_shift[DATA_WIDTH-1:0];
                    r_den[k]  <= n_den_in;
                    r_side[k] <= n_side_in;
                    r_quo[k]  <= n_quo;
                end
            end
        end
    endgenerate

    // Round up when the remainder is at least half the divisor.
    logic [DATA_WIDTH:0] n_dbl;
    logic                n_up;
    assign n_dbl = {r_rem[NS-1], 1'b0};
    assign n_up  = n_dbl >= {1'b0, r_den[NS-1]};

    t_ctl              r_octl;
    logic [SIDE_W-1:0] r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octl <= '0;
        end else if (i_en) begin
            r_octl <= r_ctl[NS-1];
        end
        if (i_en) begin
            r_qout  <= r_quo[NS-1] + (FRAC_BITS+1)'(n_up);
            r_oside <= r_side[NS-1];
        end
    end

    assign o_ctl  = r_octl;
    assign o_quo  = r_qout;
    assign o_side = r_oside;

endmodule
`default_nettype wire

// ----- rtl/chi_basis.sv -----
// Hermite basis weights from the normalized position t: t^2, t^3 over two
// multiply stages, then the four weights. Depends on chi_pkg.
`default_nettype none
module chi_basis #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 160
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire chi_pkg::t_ctl        i_ctl,
    input  wire logic [FRAC_BITS:0]   i_t,
    input  wire logic [SIDE_W-1:0]    i_side,
    output chi_pkg::t_ctl             o_ctl,
    output logic signed [FRAC_BITS+2:0] o_h1,
    output logic signed [FRAC_BITS+2:0] o_h2,
    output logic signed [FRAC_BITS+2:0] o_h3,
    output logic signed [FRAC_BITS+2:0] o_h4,
    output logic [SIDE_W-1:0]         o_side
);
    import chi_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 3;
    localparam int PW = 2 * TW;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [HW-1:0] ONE = HW'(1) << FRAC_BITS;

    t_ctl              r_ctl_a, r_ctl_b, r_ctl_c;
    logic [SIDE_W-1:0] r_side_a, r_side_b, r_side_c;
    logic [TW-1:0]     r_t_a, r_t_b, r_t2_a, r_t2_b, r_t3_b;
    logic signed [HW-1:0] r_h1, r_h2, r_h3, r_h4;

    logic [PW-1:0] n_sq, n_cu;
    assign n_sq = (PW'(i_t) * PW'(i_t)) + HALF;
    assign n_cu = (PW'(r_t2_a) * PW'(r_t_a)) + HALF;

    logic signed [HW-1:0] n_t, n_t2, n_t3;
    assign n_t  = $signed(HW'(r_t_b));
    assign n_t2 = $signed(HW'(r_t2_b));
    assign n_t3 = $signed(HW'(r_t3_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
        end
        if (i_en) begin
            r_t_a    <= i_t;
            r_t2_a   <= n_sq[FRAC_BITS +: TW];
            r_side_a <= i_side;
            r_t_b    <= r_t_a;
            r_t2_b   <= r_t2_a;
            r_t3_b   <= n_cu[FRAC_BITS +: TW];
            r_side_b <= r_side_a;
            r_h1     <= HW'(2 * n_t3 - 3 * n_t2 + ONE);
            r_h2     <= HW'(3 * n_t2 - 2 * n_t3);
            r_h3     <= HW'(n_t3 - 2 * n_t2 + n_t);
            r_h4     <= n_t3 - n_t2;
            r_side_c <= r_side_b;
        end
    end

    assign o_ctl  = r_ctl_c;
    assign o_h1   = r_h1;
    assign o_h2   = r_h2;
    assign o_h3   = r_h3;
    assign o_h4   = r_h4;
    assign o_side = r_side_c;

endmodule
`default_nettype wire

// ----- rtl/chi_blend.sv -----
// Weighted sum of values and slopes, rounding and saturation; the last stage
// is the output register. Depends on chi_pkg.
`default_nettype none
module chi_blend #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire chi_pkg::t_ctl                 i_ctl,
    input  wire logic signed [FRAC_BITS+2:0]   i_h1,
    input  wire logic signed [FRAC_BITS+2:0]   i_h2,
    input  wire logic signed [FRAC_BITS+2:0]   i_h3,
    input  wire logic signed [FRAC_BITS+2:0]   i_h4,
    input  wire logic [5*DATA_WIDTH-1:0]       i_side,
    output chi_pkg::t_ctl                      o_ctl,
    output logic [DATA_WIDTH-1:0]              o_value
);
    import chi_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int HW = FRAC_BITS + 3;
    localparam int PW = DW + HW;
    localparam int SW = DW + 4;
    localparam int MW = SW + DW + 1;
    localparam int AW = 2 * DW + 6;
    localparam int RW = AW - FRAC_BITS;

    logic signed [DW-1:0] n_y1, n_y2, n_dy1, n_dy2;
    assign n_y1  = $signed(i_side[0*DW +: DW]);
    assign n_y2  = $signed(i_side[1*DW +: DW]);
    assign n_dy1 = $signed(i_side[2*DW +: DW]);
    assign n_dy2 = $signed(i_side[3*DW +: DW]);

    t_ctl r_ctl_p, r_ctl_q, r_ctl_r, r_ctl_o;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic [DW-1:0]        r_w_p, r_w_q;
    logic signed [SW-1:0] r_s;
    logic signed [PW:0]   r_yy_q, r_yy_r;
    logic signed [MW-1:0] r_sw;
    logic [DW-1:0]        r_out;

    // Slope term: round off FRAC_BITS before scaling by the width.
    logic signed [PW:0] n_ds;
    assign n_ds = (PW+1)'(r_p3) + (PW+1)'(r_p4) + (PW+1)'(1 << (FRAC_BITS - 1));

    logic signed [AW-1:0] n_acc;
    logic signed [RW-1:0] n_res;
    logic                 n_fits;
    assign n_acc  = AW'(r_yy_r) + AW'(r_sw) + AW'(1 << (FRAC_BITS - 1));
    assign n_res  = RW'(n_acc >>> FRAC_BITS);
    assign n_fits = (n_res[RW-1:DW-1] == '0) || (n_res[RW-1:DW-1] == '1);

    logic [DW-1:0] n_sat;
    assign n_sat = n_res[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p <= '0;
            r_ctl_q <= '0;
            r_ctl_r <= '0;
            r_ctl_o <= '0;
        end else if (i_en) begin
            r_ctl_p <= i_ctl;
            r_ctl_q <= r_ctl_p;
            r_ctl_r <= r_ctl_q;
            r_ctl_o.vld <= r_ctl_r.vld;
            if (r_ctl_r.status != ST_OK) begin
                r_ctl_o.status <= r_ctl_r.status;
            end else if (!n_fits) begin
                r_ctl_o.status <= ST_SATURATED;
            end else begin
                r_ctl_o.status <= ST_OK;
            end
        end
        if (i_en) begin
            r_p1   <= PW'(n_y1)  * PW'(i_h1);
            r_p2   <= PW'(n_y2)  * PW'(i_h2);
            r_p3   <= PW'(n_dy1) * PW'(i_h3);
            r_p4   <= PW'(n_dy2) * PW'(i_h4);
            r_w_p  <= i_side[4*DW +: DW];
            r_s    <= SW'(n_ds >>> FRAC_BITS);
            r_yy_q <= (PW+1)'(r_p1) + (PW+1)'(r_p2);
            r_w_q  <= r_w_p;
            r_sw   <= MW'(r_s) * $signed(MW'(r_w_q));
            r_yy_r <= r_yy_q;
            if (r_ctl_r.status != ST_OK) begin
                r_out <= '0;
            end else if (!n_fits) begin
                r_out <= n_sat;
            end else begin
                r_out <= n_res[DW-1:0];
            end
        end
    end

    assign o_ctl   = r_ctl_o;
    assign o_value = r_out;

endmodule
`default_nettype wire

// ----- rtl/cubic_hermite_interpolator.sv -----
// Cubic Hermite interpolator, top level: input stage, pipelined divider,
// basis and blend stages. Depends on chi_pkg, chi_div, chi_basis, chi_blend.
//
// One beat in, one beat out, one item per clock sustained while the output
// is not stalled. The pipeline depth is set mostly by the divider, which
// produces one quotient bit per stage. The whole pipeline advances whenever
// the output register is empty or being taken, so a stalled result holds
// every stage and nothing is dropped. Status in tuser: 0 ok, 1 query outside
// the interval, 2 empty interval (both with value 0), 3 saturated.
`default_nettype none
module cubic_hermite_interpolator #(
    parameter int DATA_WIDTH = chi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = chi_pkg::FRAC_BITS_DEF,
    localparam int IN_W  = ((7 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // query_point, left_end, right_end, left_value, right_value,
    // left_slope, right_slope
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // interpolated
    output logic [OUT_W-1:0]      m_axis_tdata,
    // status
    output logic [1:0]            m_axis_tuser
);
    import chi_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int SIDE_W = 5 * DW;

    logic n_en;
    t_ctl blend_ctl;
    assign n_en          = !blend_ctl.vld || m_axis_tready;
    assign s_axis_tready = n_en && i_rst_n;

    logic signed [DW-1:0] n_q, n_x1, n_x2;
    assign n_q  = $signed(s_axis_tdata[0*DW +: DW]);
    assign n_x1 = $signed(s_axis_tdata[1*DW +: DW]);
    assign n_x2 = $signed(s_axis_tdata[2*DW +: DW]);

    t_ctl              r_in_ctl;
    logic [DW-1:0]     r_w, r_d;
    logic [SIDE_W-1:0] r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (n_en) begin
            r_in_ctl.vld <= s_axis_tvalid;
            if (!(n_x1 < n_x2)) begin
                r_in_ctl.status <= ST_EMPTY;
            end else if (n_q < n_x1 || n_q > n_x2) begin
                r_in_ctl.status <= ST_OUTSIDE;
            end else begin
                r_in_ctl.status <= ST_OK;
            end
        end
        if (n_en) begin
            r_w    <= n_x2 - n_x1;
            r_d    <= n_q - n_x1;
            r_side <= {n_x2 - n_x1, s_axis_tdata[3*DW +: 4*DW]};
        end
    end

    t_ctl                div_ctl, basis_ctl;
    logic [FRAC_BITS:0]  div_t;
    logic [SIDE_W-1:0]   div_side, basis_side;
    logic signed [FRAC_BITS+2:0] h1, h2, h3, h4;
    logic [DW-1:0]       value;

    chi_div #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_W     (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (r_in_ctl),
        .i_num   (r_d),
        .i_den   (r_w),
        .i_side  (r_side),
        .o_ctl   (div_ctl),
        .o_quo   (div_t),
        .o_side  (div_side)
    );

    chi_basis #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (div_ctl),
        .i_t     (div_t),
        .i_side  (div_side),
        .o_ctl   (basis_ctl),
        .o_h1    (h1),
        .o_h2    (h2),
        .o_h3    (h3),
        .o_h4    (h4),
        .o_side  (basis_side)
    );

    chi_blend #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (basis_ctl),
        .i_h1    (h1),
        .i_h2    (h2),
        .i_h3    (h3),
        .i_h4    (h4),
        .i_side  (basis_side),
        .o_ctl   (blend_ctl),
        .o_value (value)
    );

    assign m_axis_tvalid = blend_ctl.vld;
    assign m_axis_tdata  = OUT_W'(value);
    assign m_axis_tuser  = blend_ctl.status;

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OUTSIDE || m_axis_tuser == ST_EMPTY)
        |-> value == '0)
        else $error("flagged beat carries a nonzero value");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SATURATED
        |-> (value == {1'b1, {(DW-1){1'b0}}} || value == {1'b0, {(DW-1){1'b1}}}))
        else $error("saturated beat is not clamped to a range end");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("pipeline advances while the output is stalled");

endmodule
`default_nettype wire
